// ----- hdl/flpte_pkg.sv -----
// Shared types and constants of the four-level page table engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package flpte_pkg;

  localparam logic [1:0] FUNC_MAP_CHK   = 2'd0;
  localparam logic [1:0] FUNC_MAP_UNCHK = 2'd1;
  localparam logic [1:0] FUNC_UNMAP     = 2'd2;
  localparam logic [1:0] FUNC_CHECK     = 2'd3;

  localparam logic [1:0] CFG_TABLE_BASE = 2'd0;
  localparam logic [1:0] CFG_WIN_LOW    = 2'd1;
  localparam logic [1:0] CFG_WIN_HIGH   = 2'd2;

  localparam int unsigned PA_W = 52;
  localparam int unsigned VA_W = 48;

  typedef struct packed {
    logic [1:0]       func;
    logic [VA_W-1:0]  virtual_address;
    logic [PA_W-1:0]  physical_address;
    logic [63:0]      entry_flags;
    logic [15:0]      page_count;
  } req_word_t;

  typedef struct packed {
    logic ok;
  } rsp_word_t;

endpackage
`default_nettype wire

// ----- hdl/flpte_req_if.sv -----
// Request channel of the page table engine.
// Depends on flpte_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface flpte_req_if;
  logic                 valid;
  logic                 ready;
  flpte_pkg::req_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/flpte_rsp_if.sv -----
// Response channel of the page table engine.
// Depends on flpte_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface flpte_rsp_if;
  logic                 valid;
  logic                 ready;
  flpte_pkg::rsp_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/four_level_page_table_engine_unit.sv -----
// A request stops at the first failing page. One request at a time.
// The table memory is walked through its single port, each entry read being
// evaluated before the next is read. After reset a clearing pass zeroes all
// TABLE_PAGES*512 entries of the store; no word is taken meanwhile.
// Configuration registers and the allocator reset at once.
`timescale 1ns / 1ps
`default_nettype none
module four_level_page_table_engine_unit #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  flpte_req_if.sink                        in_i,
  flpte_rsp_if.source                      out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [flpte_pkg::PA_W-1:0]  cfg_data_i
);
  import flpte_pkg::*;

  localparam int unsigned DEPTH = TABLE_PAGES * 512;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned NW    = $clog2(TABLE_PAGES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [NW-1:0] PAGES_N   = NW'(TABLE_PAGES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PAGE  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_RES   = 4'd5;
  localparam logic [3:0] S_LEAF  = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [PA_W-1:0] base_q, wlow_q, whigh_q;
  logic [NW-1:0]   nfree_q, nfree_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [1:0]      func_q, func_d;
  logic [VA_W-1:0] va_q, va_d;
  logic [PA_W:0]   pa_q, pa_d;
  logic [63:0]     flags_q, flags_d;
  logic [15:0]     rem_q, rem_d;
  logic [1:0]      level_q, level_d;
  logic [PW-1:0]   page_q, page_d;
  logic [63:0]     ent_q, ent_d;
  logic            ok_q, ok_d;

  logic [63:0]     mem [DEPTH];
  logic [63:0]     rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [63:0]     mem_wdata;

  logic [8:0]      idx;
  logic            is_map;
  logic [39:0]     fresh_pfn;
  logic [40:0]     diff;
  logic            win_ok;

  always_comb begin
    unique case (level_q)
      2'd0: idx = va_q[47:39];
      2'd1: idx = va_q[38:30];
      2'd2: idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign is_map    = (func_q == FUNC_MAP_CHK) || (func_q == FUNC_MAP_UNCHK);
  assign fresh_pfn = base_q[51:12] + 40'(nfree_q);
  assign diff      = {1'b0, ent_q[51:12]} - {1'b0, base_q[51:12]};
  assign win_ok    = ({1'b0, wlow_q} <= pa_q)
                     && ({1'b0, pa_q} + 54'd4095 <= {2'b00, whigh_q});

  always_comb begin
    state_d   = state_q;
    nfree_d   = nfree_q;
    clr_d     = clr_q;
    func_d    = func_q;
    va_d      = va_q;
    pa_d      = pa_q;
    flags_d   = flags_q;
    rem_d     = rem_q;
    level_d   = level_q;
    page_d    = page_q;
    ent_d     = ent_q;
    ok_d      = ok_q;
    mem_we    = 1'b0;
    mem_addr  = AW'({page_q, idx});
    mem_wdata = 64'd0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          func_d  = in_i.data.func;
          va_d    = in_i.data.virtual_address;
          pa_d    = {1'b0, in_i.data.physical_address};
          flags_d = in_i.data.entry_flags;
          rem_d   = in_i.data.page_count;
          if (in_i.data.page_count == 16'd0) begin
            ok_d    = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_PAGE;
          end
        end
      end
      S_PAGE: begin
        level_d = 2'd0;
        page_d  = '0;
        if ((func_q != FUNC_CHECK && va_q[11:0] != 12'd0)
            || (is_map && pa_q[11:0] != 12'd0)
            || (func_q == FUNC_MAP_CHK && !win_ok)) begin
          ok_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_EVAL;
      S_EVAL: begin
        ent_d = rd_q;
        if (!rd_q[0]) begin
          if (is_map) begin
            if (nfree_q >= PAGES_N) begin
              ok_d    = 1'b0;
              state_d = S_DONE;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {12'd0, fresh_pfn, 12'h003};
              ent_d     = mem_wdata;
              nfree_d   = nfree_q + 1'b1;
              state_d   = S_RES;
            end
          end else begin
            ok_d    = 1'b0;
            state_d = S_DONE;
          end
        end else if (!is_map && (level_q == 2'd3
                                 || (level_q != 2'd0 && rd_q[7]))) begin
          mem_we  = (func_q == FUNC_UNMAP);
          state_d = S_NEXT;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (diff[40] || diff[39:0] >= 40'(nfree_q)) begin
          ok_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          page_d  = diff[PW-1:0];
          level_d = level_q + 1'b1;
          state_d = (is_map && level_q == 2'd2) ? S_LEAF : S_RD;
        end
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = {flags_q[63:52], pa_q[51:12], flags_q[11:1], 1'b1};
        state_d   = S_NEXT;
      end
      S_NEXT: begin
        if (rem_q == 16'd1) begin
          ok_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          rem_d   = rem_q - 1'b1;
          va_d    = va_q + 48'h1000;
          pa_d    = pa_q + 53'h1000;
          state_d = S_PAGE;
        end
      end
      S_DONE: if (out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      nfree_q <= NW'(1);
      clr_q   <= '0;
      ok_q    <= 1'b0;
      base_q  <= '0;
      wlow_q  <= '0;
      whigh_q <= '1;
    end else begin
      state_q <= state_d;
      nfree_q <= nfree_d;
      clr_q   <= clr_d;
      ok_q    <= ok_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TABLE_BASE: base_q  <= cfg_data_i;
          CFG_WIN_LOW:    wlow_q  <= cfg_data_i;
          CFG_WIN_HIGH:   whigh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    va_q    <= va_d;
    pa_q    <= pa_d;
    flags_q <= flags_d;
    rem_q   <= rem_d;
    level_q <= level_d;
    page_q  <= page_d;
    ent_q   <= ent_d;
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = (state_q == S_DONE);
  assign out_o.data.ok   = ok_q;

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("ready while result pending");
  a_alloc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfree_q >= NW'(1) && nfree_q <= PAGES_N) else $error("allocator out of range");
  a_alloc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfree_q != $past(nfree_q) |-> nfree_q == $past(nfree_q) + 1'b1)
    else $error("allocator jumped");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_i.ready && !out_o.valid) else $error("busy in clear");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_four_level_page_table_engine_unit.sv -----
// Self-checking bench for the four-level page table engine: a queue-fed driver,
// a response monitor and a local page-walk predictor with its own table store.
// Depends on flpte_pkg, flpte_req_if, flpte_rsp_if and the engine RTL.
`timescale 1ns / 1ps
module tb_four_level_page_table_engine_unit;
  import flpte_pkg::*;

  localparam int unsigned TP         = 16;
  localparam logic [63:0] ADDR_FIELD = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] LOW52      = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] PG_BYTES   = 64'd4096;
  localparam int unsigned WDOG_LIMIT = 60000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_TABLE_BASE;
  logic [PA_W-1:0] cfg_data_i = '0;

  flpte_req_if req_if ();
  flpte_rsp_if rsp_if ();

  four_level_page_table_engine_unit #(.TABLE_PAGES(TP)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_if), .out_o(rsp_if),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] pt_mem [0:TP*512-1];
  int unsigned next_tbl;
  logic [63:0] reg_base, reg_wlo, reg_whi;

  req_word_t req_backlog[$];
  bit ok_expected[$];
  logic [47:0] hot_va [4];
  bit calm = 1'b0;
  int unsigned n_req = 0, n_rsp = 0, n_ok = 0, n_err = 0, idle_cyc = 0;

  function automatic int unsigned lvl_ix(input logic [63:0] va, input int unsigned sh);
    return int'((va >> sh) & 64'h1FF);
  endfunction

  function automatic bit table_of(input logic [63:0] e, output int unsigned pg);
    logic [63:0] a, b, k;
    a = e & ADDR_FIELD;
    b = reg_base & ADDR_FIELD;
    pg = 0;
    if (a < b) return 1'b0;
    k = (a - b) >> 12;
    if (k >= next_tbl || k >= TP) return 1'b0;
    pg = int'(k);
    return 1'b1;
  endfunction

  function automatic bit grab_table(output logic [63:0] e);
    int unsigned k;
    e = '0;
    if (next_tbl >= TP) return 1'b0;
    k = next_tbl;
    next_tbl++;
    for (int j = 0; j < 512; j++) pt_mem[k*512+j] = '0;
    e = (((reg_base & ADDR_FIELD) + 64'(k) * PG_BYTES) & ADDR_FIELD) | 64'h3;
    return 1'b1;
  endfunction

  function automatic bit map_one(input logic [63:0] va, input logic [63:0] pa,
                                 input logic [63:0] flags, input bit chk);
    int unsigned pg, ix;
    logic [63:0] fresh;
    pg = 0;
    if (va[11:0] != 0 || pa[11:0] != 0) return 1'b0;
    if (chk && (pa < reg_wlo || pa > reg_whi || reg_whi - pa < PG_BYTES - 1)) return 1'b0;
    for (int lv = 0; lv < 3; lv++) begin
      ix = pg * 512 + lvl_ix(va, 39 - 9 * lv);
      if (!pt_mem[ix][0]) begin
        if (!grab_table(fresh)) return 1'b0;
        pt_mem[ix] = fresh;
      end
      if (!table_of(pt_mem[ix], pg)) return 1'b0;
    end
    pt_mem[pg*512+lvl_ix(va, 12)] = (pa & ADDR_FIELD) | (flags & ~ADDR_FIELD) | 64'h1;
    return 1'b1;
  endfunction

  function automatic bit walk_one(input logic [63:0] va, input bit clr);
    int unsigned pg, ix;
    pg = 0;
    if (clr && va[11:0] != 0) return 1'b0;
    ix = lvl_ix(va, 39);
    if (!pt_mem[ix][0] || !table_of(pt_mem[ix], pg)) return 1'b0;
    for (int lv = 0; lv < 2; lv++) begin
      ix = pg * 512 + lvl_ix(va, 30 - 9 * lv);
      if (!pt_mem[ix][0]) return 1'b0;
      if (pt_mem[ix][7]) begin
        if (clr) pt_mem[ix] = '0;
        return 1'b1;
      end
      if (!table_of(pt_mem[ix], pg)) return 1'b0;
    end
    ix = pg * 512 + lvl_ix(va, 12);
    if (!pt_mem[ix][0]) return 1'b0;
    if (clr) pt_mem[ix] = '0;
    return 1'b1;
  endfunction

  function automatic bit range_ok(input req_word_t w);
    bit ok;
    logic [63:0] off;
    ok = (w.page_count != 0);
    for (int unsigned i = 0; ok && i < w.page_count; i++) begin
      off = 64'(i) * PG_BYTES;
      if (w.func == FUNC_MAP_CHK || w.func == FUNC_MAP_UNCHK)
        ok = map_one(64'(w.virtual_address) + off, 64'(w.physical_address) + off,
                     w.entry_flags, w.func == FUNC_MAP_CHK);
      else
        ok = walk_one(64'(w.virtual_address) + off, w.func == FUNC_UNMAP);
    end
    return ok;
  endfunction

  task automatic queue_req(input logic [1:0] f, input logic [47:0] va, input logic [51:0] pa,
                           input logic [63:0] fl, input logic [15:0] cnt);
    req_word_t w;
    w.func = f;
    w.virtual_address = va;
    w.physical_address = pa;
    w.entry_flags = fl;
    w.page_count = cnt;
    req_backlog.push_back(w);
  endtask

  task automatic queue_random();
    req_word_t w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w.func = 2'($urandom_range(0, 3));
    w.entry_flags = {$urandom, $urandom};
    if (r < 10) begin
      w.virtual_address = {16'($urandom), $urandom};
      w.physical_address = {20'($urandom), $urandom};
      w.page_count = 16'($urandom_range(0, 3));
    end else begin
      w.virtual_address = hot_va[$urandom_range(0, 3)] + 48'($urandom_range(0, 63)) * 48'd4096;
      if ($urandom_range(0, 1))
        w.physical_address = {20'($urandom), $urandom} & ADDR_FIELD[51:0];
      else
        w.physical_address = 52'((reg_wlo & ADDR_FIELD) + 64'($urandom_range(0, 1100)) * PG_BYTES
                                 - PG_BYTES);
      r = $urandom_range(0, 99);
      w.page_count = (r < 80) ? 16'($urandom_range(1, 4)) :
                     (r < 95) ? 16'($urandom_range(5, 32)) : 16'($urandom_range(33, 64));
    end
    req_backlog.push_back(w);
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_if.valid || ok_expected.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [51:0] base, input logic [51:0] wlo,
                          input logic [51:0] whi);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_TABLE_BASE; cfg_data_i <= base;
    reg_base = 64'(base);
    @(posedge clk_i);
    cfg_idx_i <= CFG_WIN_LOW; cfg_data_i <= wlo;
    reg_wlo = 64'(wlo);
    @(posedge clk_i);
    cfg_idx_i <= CFG_WIN_HIGH; cfg_data_i <= whi;
    reg_whi = 64'(whi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        ok_expected.push_back(range_ok(req_if.data));
        n_req++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
          req_if.valid <= 1'b1;
          req_if.data <= req_backlog.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_rsp++;
      if (ok_expected.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected response ok=%0b", rsp_if.data.ok);
      end else begin
        if (ok_expected[0]) n_ok++;
        if (rsp_if.data.ok !== ok_expected[0]) begin
          n_err++;
          if (n_err <= 10)
            $display("response %0d: expected ok=%0b actual ok=%0b",
                     n_rsp, ok_expected[0], rsp_if.data.ok);
        end
        void'(ok_expected.pop_front());
      end
    end
    rsp_if.ready <= calm || ($urandom_range(0, 99) >= 32);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    for (int j = 0; j < TP * 512; j++) pt_mem[j] = '0;
    next_tbl = 1;
    reg_base = '0;
    reg_wlo = '0;
    reg_whi = LOW52;
    hot_va[0] = '0;
    hot_va[1] = 48'h0080_0000_0000;
    hot_va[2] = {16'($urandom), $urandom} & 48'hFFFF_FFFF_F000;
    hot_va[3] = 48'hFFFF_FFFE_0000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_regs('0, '0, LOW52[51:0]);

    queue_req(FUNC_MAP_CHK, '0, '0, '1, 16'd1);
    queue_req(FUNC_CHECK, 48'h0000_0000_0FFF, '0, '0, 16'd1);
    queue_req(FUNC_MAP_UNCHK, 48'h0000_0000_1001, 52'h2000, '0, 16'd1);
    queue_req(FUNC_MAP_UNCHK, 48'h0000_0000_1000, 52'h2001, '0, 16'd1);
    queue_req(FUNC_MAP_CHK, 48'h0000_0000_1000, 52'h2000, '0, 16'd0);
    queue_req(FUNC_MAP_UNCHK, 48'h0000_0000_1000, 52'hF_FFFF_FFFF_F000, 64'h80, 16'd2);
    queue_req(FUNC_MAP_CHK, 48'h0000_0000_8000, 52'hF_FFFF_FFFF_F000, '0, 16'd2);
    queue_req(FUNC_MAP_CHK, 48'hFFFF_FFFF_F000, 52'h10_0000, '1, 16'd2);
    queue_req(FUNC_CHECK, 48'hFFFF_FFFF_F000, '0, '0, 16'd2);
    queue_req(FUNC_MAP_CHK, 48'h0000_0010_0000, 52'h40_0000, 64'h6, 16'd4);
    queue_req(FUNC_CHECK, 48'h0000_0010_0000, '0, '0, 16'd4);
    queue_req(FUNC_UNMAP, 48'h0000_0010_1000, '0, '0, 16'd1);
    queue_req(FUNC_CHECK, 48'h0000_0010_0000, '0, '0, 16'd4);
    queue_req(FUNC_UNMAP, 48'h0000_0010_1000, '0, '0, 16'd1);
    queue_req(FUNC_UNMAP, 48'h0000_0010_2008, '0, '0, 16'd1);
    queue_req(FUNC_UNMAP, 48'h7000_0000_0000, '0, '0, 16'hFFFF);
    for (int k = 1; k <= 6; k++)
      queue_req(FUNC_MAP_UNCHK, 48'(k) << 39, 52'h5000, '0, 16'd1);
    for (int n = 0; n < 300; n++) queue_random();
    wait_drained();

    set_regs('0, 52'h10_0000, 52'h3F_FFFF);
    calm = 1'b1;
    for (int n = 0; n < 150; n++) queue_random();
    wait_drained();
    calm = 1'b0;
    for (int n = 0; n < 150; n++) queue_random();
    wait_drained();

    set_regs(52'h4_0000, LOW52[51:0], '0);
    for (int n = 0; n < 200; n++) queue_random();
    wait_drained();

    set_regs(52'hF_FFFF_FFFF_F000, '0, LOW52[51:0]);
    for (int n = 0; n < 200; n++) queue_random();
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("covered %0d requests (%0d ok) over four register settings", n_req, n_ok);
    $display("responses checked: %0d, mismatches: %0d", n_rsp, n_err);
    if (n_err == 0 && ok_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
